// ----- hw/rtl/iprc_pkg.sv -----
package iprc_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int MODE_W  = 2;
  localparam int EIDX_W  = 12;
  localparam int COUNT_W = 13;
  localparam int VERD_W  = 2;
  localparam int CFG_W   = 1;

  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_ALLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WR_DENY  = 2'd2;

  localparam logic [VERD_W-1:0] VERDICT_ALLOWED = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_DENIED  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_UNKNOWN = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ALLOW_COUNT = 1'd0;
  localparam logic [CFG_W-1:0] CFG_DENY_COUNT  = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [PORT_W-1:0] port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic              load_pkt;
    logic              start_pass;
    logic              deny_pass;
    logic              scan;
    logic              wr_allow;
    logic              wr_deny;
    logic              load_out;
    logic [VERD_W-1:0] verdict;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic done;
    logic out_busy;
  } stat_t;

endpackage

// ----- hw/rtl/ip_range_allow_deny_classifier_unit.sv -----
// Write items and unused modes leave the sequencer idle; the next item can follow on the next edge.
// Classify scans the allow table, then the deny table, one entry read per cycle; the
// counts are clamped to 4096, and a hit ends the scan.
// With no hit the verdict is UNKNOWN. The next item is taken only once the result is
// loaded into the output register; a stalled result holds the sequencer.
// Reset clears the counts, the sequencer and the result valid; table RAMs are not cleared.
module ip_range_allow_deny_classifier_unit
  import iprc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [ADDR_W-1:0]  src_addr,
  input  logic [ADDR_W-1:0]  dst_addr,
  input  logic [PORT_W-1:0]  src_port,
  input  logic [PORT_W-1:0]  dst_port,
  input  logic [EIDX_W-1:0]  entry_index,
  input  logic [ADDR_W-1:0]  range_first,
  input  logic [ADDR_W-1:0]  range_last,
  input  logic [PORT_W-1:0]  entry_port,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [VERD_W-1:0]  verdict
);

  cmd_t  cmd;
  stat_t stat;

  iprc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (mode),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  iprc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .src_port     (src_port),
    .dst_port     (dst_port),
    .entry_index  (entry_index),
    .range_first  (range_first),
    .range_last   (range_last),
    .entry_port   (entry_port),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict)
  );

endmodule

// ----- hw/rtl/iprc_ram.sv -----
module iprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/iprc_ctrl.sv -----
module iprc_ctrl
  import iprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [MODE_W-1:0] mode,
  output logic              item_stall,
  input  stat_t             stat,
  output cmd_t              cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN_A = 4'b0010,
    ST_SCAN_D = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [VERD_W-1:0] verdict_q, verdict_q_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    verdict_q_next = verdict_q;
    cmd            = '0;
    cmd.verdict    = verdict_q;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (mode == MODE_CLASSIFY) begin
            cmd.load_pkt   = 1'b1;
            cmd.start_pass = 1'b1;
            cmd.deny_pass  = 1'b0;
            state_next     = ST_SCAN_A;
          end else if (mode == MODE_WR_ALLOW) begin
            cmd.wr_allow = 1'b1;
          end else if (mode == MODE_WR_DENY) begin
            cmd.wr_deny = 1'b1;
          end
        end
      end
      ST_SCAN_A: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          verdict_q_next = VERDICT_ALLOWED;
          state_next     = ST_FINISH;
        end else if (stat.done) begin
          // start_pass wins over scan in the datapath
          cmd.start_pass = 1'b1;
          cmd.deny_pass  = 1'b1;
          state_next     = ST_SCAN_D;
        end
      end
      ST_SCAN_D: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          verdict_q_next = VERDICT_DENIED;
          state_next     = ST_FINISH;
        end else if (stat.done) begin
          verdict_q_next = VERDICT_UNKNOWN;
          state_next     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    verdict_q <= verdict_q_next;
  end

endmodule

// ----- hw/rtl/iprc_dp.sv -----
module iprc_dp
  import iprc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]  src_addr,
  input  logic [ADDR_W-1:0]  dst_addr,
  input  logic [PORT_W-1:0]  src_port,
  input  logic [PORT_W-1:0]  dst_port,
  input  logic [EIDX_W-1:0]  entry_index,
  input  logic [ADDR_W-1:0]  range_first,
  input  logic [ADDR_W-1:0]  range_last,
  input  logic [PORT_W-1:0]  entry_port,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [VERD_W-1:0]  verdict
);

  logic [COUNT_W-1:0] allow_count, deny_count;
  logic [ADDR_W-1:0]  sa, da;
  logic [PORT_W-1:0]  sp, dp;
  logic               sel_deny;
  logic [CNT_W-1:0]   addr;
  logic               pend;

  logic [COUNT_W-1:0] count_sel;
  logic [CNT_W-1:0]   lim;
  logic               issue;
  logic               idx_ok;
  entry_t             wentry, allow_rd, deny_rd, cur;
  logic               in_src, in_dst, port_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_count <= '0;
      deny_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALLOW_COUNT: allow_count <= cfg_data;
        CFG_DENY_COUNT:  deny_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp count to the table depth
  always_comb begin
    count_sel = sel_deny ? deny_count : allow_count;
    if (32'(count_sel) > TABLE_DEPTH) begin
      lim = CNT_W'(TABLE_DEPTH);
    end else begin
      lim = CNT_W'(count_sel);
    end
  end

  assign issue  = cmd.scan && !cmd.start_pass && (addr < lim);
  assign idx_ok = (32'(entry_index) < TABLE_DEPTH);

  assign wentry.first = range_first;
  assign wentry.last  = range_last;
  assign wentry.port  = entry_port;

  iprc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_allow_ram (
    .clk   (clk),
    .we    (cmd.wr_allow && idx_ok),
    .waddr (entry_index[IDX_W-1:0]),
    .wdata (wentry),
    .re    (issue && !sel_deny),
    .raddr (addr[IDX_W-1:0]),
    .rdata (allow_rd)
  );

  iprc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_deny_ram (
    .clk   (clk),
    .we    (cmd.wr_deny && idx_ok),
    .waddr (entry_index[IDX_W-1:0]),
    .wdata (wentry),
    .re    (issue && sel_deny),
    .raddr (addr[IDX_W-1:0]),
    .rdata (deny_rd)
  );

  // entry read last cycle is checked now
  always_comb begin
    cur     = sel_deny ? deny_rd : allow_rd;
    in_src  = (sa >= cur.first) && (sa <= cur.last);
    in_dst  = (da >= cur.first) && (da <= cur.last);
    port_ok = (cur.port == '0) || (cur.port == sp) || (cur.port == dp);
  end

  assign stat.hit      = pend && (in_src || in_dst) && port_ok;
  assign stat.done     = !pend && !(addr < lim);
  assign stat.out_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      sa <= src_addr;
      da <= dst_addr;
      sp <= src_port;
      dp <= dst_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr     <= '0;
      pend     <= 1'b0;
      sel_deny <= 1'b0;
    end else if (cmd.start_pass) begin
      addr     <= '0;
      pend     <= 1'b0;
      sel_deny <= cmd.deny_pass;
    end else if (cmd.scan) begin
      pend <= issue;
      if (issue) begin
        addr <= addr + CNT_W'(1);
      end
    end else begin
      pend <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      verdict <= cmd.verdict;
    end
  end

endmodule
